### rtl/assert_macros.svh
// Shared assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define PCU_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define PCU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define PCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/pcu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcu_pkg;

	// Record and word geometry.
	localparam int REC_BITS     = 31;
	localparam int WORD_BITS    = 32;
	localparam int FIRST_OFFSET = 8;
	localparam int COUNT_LSB    = 4;
	localparam int CNT_W        = 4;
	localparam int QTR_LSB      = 29;
	localparam int POS_W        = $clog2(WORD_BITS) + 1;
	localparam int OFS_W        = $clog2(WORD_BITS);
	localparam int FILL_W       = $clog2(REC_BITS + 1);

	// Results per word and output queue depth.
	localparam int MAX_OUT    = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int NUM_W      = $clog2(MAX_OUT + 1);

	// Register map. Registers are decoded by word index, paddr[PADDR_W-1:2].
	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_SIDE = 3'd0;
	localparam logic [PADDR_W-3:0] IDX_SIDE  = 1'b0;

	// Unpacking state carried from word to word.
	typedef struct packed {
		logic [REC_BITS-1:0]        acc;
		logic [FILL_W-1:0]          fill;
		logic [OFS_W-1:0]           offset;
		logic [CNT_W-1:0]           remaining;
		logic [1:0][CNT_W-1:0]      half_cnt;
	} unpack_state_t;

	// One emitted candidate.
	typedef struct packed {
		logic [REC_BITS-1:0] candidate;
		logic                half;
		logic [CNT_W-1:0]    slot;
		logic                last;
	} result_t;

endpackage

`default_nettype wire

### rtl/pcu_step.sv
`timescale 1ns / 1ps
`default_nettype none

module pcu_step
	import pcu_pkg::*;
(
	input  wire logic [WORD_BITS-1:0]    word,
	input  wire logic                    first_word,
	input  wire logic                    side,
	input  wire unpack_state_t           cur,
	output unpack_state_t                nxt,
	output result_t [MAX_OUT-1:0]        res,
	output logic [NUM_W-1:0]             num
);

	unpack_state_t       st0;
	logic [WORD_BITS-1:0] chunk1, chunk2, bits1, mask1;
	logic [POS_W-1:0]    need1, end1, avail1, avail2;
	logic                done1, go2, done2, e1, e2;
	logic [REC_BITS-1:0] rec1, rec2;
	logic [1:0]          q1, q2;
	logic [CNT_W-1:0]    rem1, rem2;
	logic [1:0][CNT_W-1:0] hc1, hc2;
	result_t             r1, r2;

	always_comb begin
		// A first word restarts the bank from its own count field.
		st0 = cur;
		if (first_word) begin
			st0.remaining = word[COUNT_LSB +: CNT_W];
			st0.acc       = '0;
			st0.fill      = '0;
			st0.half_cnt  = '0;
			st0.offset    = OFS_W'(FIRST_OFFSET);
		end

		// First record: finish the one in progress, or keep gathering bits.
		chunk1 = word >> st0.offset;
		need1  = POS_W'(REC_BITS) - POS_W'(st0.fill);
		avail1 = POS_W'(WORD_BITS) - POS_W'(st0.offset);
		end1   = POS_W'(st0.offset) + need1;
		done1  = (st0.remaining != '0) && (end1 <= POS_W'(WORD_BITS));
		mask1  = (WORD_BITS'(1) << need1) - WORD_BITS'(1);
		bits1  = chunk1 & mask1;
		rec1   = st0.acc | REC_BITS'(bits1 << st0.fill);
		q1     = rec1[QTR_LSB +: 2];
		e1     = done1 && (q1[1] == side);
		rem1   = st0.remaining - CNT_W'(done1);
		hc1    = st0.half_cnt;
		if (e1) begin
			hc1[q1[0]] = st0.half_cnt[q1[0]] + CNT_W'(1);
		end

		// Second record: starts fresh right after the first one.
		go2    = done1 && (rem1 != '0) && (end1 < POS_W'(WORD_BITS));
		chunk2 = word >> end1[OFS_W-1:0];
		avail2 = POS_W'(WORD_BITS) - end1;
		done2  = go2 && (avail2 >= POS_W'(REC_BITS));
		rec2   = REC_BITS'(chunk2);
		q2     = rec2[QTR_LSB +: 2];
		e2     = done2 && (q2[1] == side);
		rem2   = rem1 - CNT_W'(done2);
		hc2    = hc1;
		if (e2) begin
			hc2[q2[0]] = hc1[q2[0]] + CNT_W'(1);
		end

		r1.candidate = rec1;
		r1.half      = q1[0];
		r1.slot      = st0.half_cnt[q1[0]];
		r1.last      = !e2;
		r2.candidate = rec2;
		r2.half      = q2[0];
		r2.slot      = hc1[q2[0]];
		r2.last      = 1'b1;

		// Compact the kept records into the lower result slots.
		res[0] = e1 ? r1 : r2;
		res[1] = r2;
		num    = NUM_W'(e1) + NUM_W'(e2);

		// Next state.
		nxt = st0;
		if (st0.remaining != '0) begin
			nxt.remaining = rem2;
			nxt.half_cnt  = hc2;
			if (!done1) begin
				nxt.acc    = st0.acc | REC_BITS'(chunk1 << st0.fill);
				nxt.fill   = st0.fill + FILL_W'(avail1);
				nxt.offset = '0;
			end else if (!go2) begin
				nxt.acc    = '0;
				nxt.fill   = '0;
				nxt.offset = (end1 >= POS_W'(WORD_BITS)) ? '0 : end1[OFS_W-1:0];
			end else if (done2) begin
				nxt.acc    = '0;
				nxt.fill   = '0;
				nxt.offset = '0;
			end else begin
				nxt.acc    = REC_BITS'(chunk2);
				nxt.fill   = FILL_W'(avail2);
				nxt.offset = '0;
			end
			if (rem2 == '0) begin
				nxt.acc    = '0;
				nxt.fill   = '0;
				nxt.offset = '0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/packed_candidate_unpacker_core.sv
// A word is registered in the input stage at acceptance, and its records are
// written to the output queue once the queue has room for two more entries.
// Throughput: one word per cycle while each word yields at most one record and the
// output is not stalled; a word that yields two records fills two entries of the 4-entry queue.
// Reset (arst_n low, asynchronous): unpacking state, queue and side clear to 0.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module packed_candidate_unpacker_core
	import pcu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Word channel.
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic [WORD_BITS-1:0]  word,
	input  wire logic                  first_word,
	// Candidate channel.
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [REC_BITS-1:0]        candidate,
	output logic                       half,
	output logic [CNT_W-1:0]           slot,
	output logic                       last_of_run,
	// Configuration port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic                  side_q;
	logic                  s1_valid_q;
	logic [WORD_BITS-1:0]  word_s1;
	logic                  first_s1;
	unpack_state_t         state_q;
	unpack_state_t         state_nxt;
	result_t [MAX_OUT-1:0] res;
	logic [NUM_W-1:0]      num;
	result_t               fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]      wr_q, rd_q;
	logic [PTR_W:0]        count_q;
	logic                  s1_fire, item_take, pop;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == IDX_SIDE) ? {31'b0, side_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[PADDR_W-1:2] == IDX_SIDE)) begin
			side_q <= pwdata[0];
		end
	end

	// Input stage: the word waits here until the queue has room for its records.
	assign s1_fire    = s1_valid_q && (count_q <= (PTR_W+1)'(FIFO_DEPTH - MAX_OUT));
	assign item_stall = s1_valid_q && !s1_fire;
	assign item_take  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_take) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			word_s1  <= word;
			first_s1 <= first_word;
		end
	end

	// Unpacking logic for one word.
	pcu_step u_step (
		.word       (word_s1),
		.first_word (first_s1),
		.side       (side_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res),
		.num        (num)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_fire) begin
			state_q <= state_nxt;
		end
	end

	// Output queue: up to two pushes and one pop per cycle.
	assign pop = result_valid && !result_stall;

	always_ff @(posedge clk) begin
		if (s1_fire && (num != '0)) begin
			fifo_q[wr_q] <= res[0];
		end
		if (s1_fire && (num == NUM_W'(MAX_OUT))) begin
			fifo_q[wr_q + PTR_W'(1)] <= res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (s1_fire) begin
				wr_q <= wr_q + PTR_W'(num);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			count_q <= count_q + (s1_fire ? (PTR_W+1)'(num) : '0) - (PTR_W+1)'(pop);
		end
	end

	assign result_valid = (count_q != '0);
	assign candidate    = fifo_q[rd_q].candidate;
	assign half         = fifo_q[rd_q].half;
	assign slot         = fifo_q[rd_q].slot;
	assign last_of_run  = fifo_q[rd_q].last;

	// Checks on the queue and the unpacking state.
	`PCU_ASSERT_NEVER(a_fifo_over, clk, arst_n, count_q > (PTR_W+1)'(FIFO_DEPTH))
	`PCU_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_valid_q && !s1_fire, s1_valid_q)
	`PCU_ASSERT_IMPLIES(a_idle_clean, clk, arst_n, state_q.remaining == '0,
		(state_q.fill == '0) && (state_q.acc == '0))
	`PCU_ASSERT_NEVER(a_fill_range, clk, arst_n, state_q.fill >= FILL_W'(REC_BITS))

endmodule

`default_nettype wire
